### rtl/core/crd_pkg.sv
`default_nettype none

package crd_pkg;

    localparam int MAX_RESOURCES_DEF = 8;
    localparam int PACKED_ENTRIES    = 8;
    localparam int TIME_W            = 24;
    localparam logic [TIME_W-1:0] TIME_MAX = 24'hFF_FFFF;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    localparam logic [3:0]  COUNT_RST  = 4'd8;
    localparam logic [31:0] LEVELS_RST = 32'd0;
    localparam logic [63:0] COSTS_RST  = 64'd0;
    localparam logic [15:0] SPREAD_RST = 16'd40;

    typedef enum logic [1:0] {
        REG_COUNT  = 2'd0,
        REG_LEVELS = 2'd1,
        REG_COSTS  = 2'd2,
        REG_SPREAD = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPREAD,
        ST_CHECK,
        ST_SELECT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [3:0]  job_level;
        logic [9:0]  job_length;
        logic [15:0] aircraft_tag;
    } job_t;

    typedef struct packed {
        logic              assigned;
        logic [2:0]        resource_index;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] finish_time;
        logic              spread_mode;
        logic [15:0]       tag_out;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/capable_resource_dispatcher_core.sv
`default_nettype none

// Channel   Signals                              Dir  Content
// job       job_valid / job_ready / job          in   level, length, aircraft tag
// result    result_valid / result_ready / result out  pick, start, finish, rule, tag
// config    psel penable pwrite paddr pwdata     in   APB, 64-bit regs at 8*i
//           prdata pready                        out
//
// A job runs through the spread walk, a check step, the pick walk and a final step
// before the next transfer; with no resource in use it goes straight to the final
// step. The single compare unit walks the free-time entries one a cycle, once for
// the min/max spread and once for the pick.
// Reset clears the free times and loads the register defaults; no clearing pass.
// A pending result sits in the output register, so a new job is taken while it waits;
// the following job stalls only at its final step if that result is still untaken.
module capable_resource_dispatcher_core #(
    parameter int MAX_RESOURCES = crd_pkg::MAX_RESOURCES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // job channel
    input  wire logic                       job_valid,
    output logic                            job_ready,
    input  wire crd_pkg::job_t              job,
    // result channel
    output logic                            result_valid,
    input  wire logic                       result_ready,
    output crd_pkg::result_t                result,
    // configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [crd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [crd_pkg::DATA_W-1:0] pwdata,
    output logic      [crd_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import crd_pkg::*;

    // Entries reachable through the packed level/cost registers.
    localparam int ACT_MAX = (MAX_RESOURCES < PACKED_ENTRIES) ? MAX_RESOURCES
                                                               : PACKED_ENTRIES;
    localparam int CNT_W = $clog2(ACT_MAX + 1);
    localparam int IDX_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;

    // ---------------- configuration registers ----------------
    logic [3:0]  resource_count_reg;
    logic [31:0] resource_levels_reg;
    logic [63:0] resource_costs_reg;
    logic [15:0] spread_limit_reg;

    logic     cfg_write;
    reg_idx_t cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resource_count_reg  <= COUNT_RST;
            resource_levels_reg <= LEVELS_RST;
            resource_costs_reg  <= COSTS_RST;
            spread_limit_reg    <= SPREAD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_COUNT:  resource_count_reg  <= pwdata[3:0];
                REG_LEVELS: resource_levels_reg <= pwdata[31:0];
                REG_COSTS:  resource_costs_reg  <= pwdata;
                REG_SPREAD: spread_limit_reg    <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_COUNT:  prdata = {60'd0, resource_count_reg};
            REG_LEVELS: prdata = {32'd0, resource_levels_reg};
            REG_COSTS:  prdata = resource_costs_reg;
            REG_SPREAD: prdata = {48'd0, spread_limit_reg};
            default:    prdata = '0;
        endcase
    end

    // ---------------- sequencer and datapath state ----------------
    state_t state_reg, state_next;

    job_t              job_reg;
    logic [CNT_W-1:0]  n_reg;        // resources in use for this job
    logic [CNT_W-1:0]  cnt_reg;      // entry being visited
    logic [TIME_W-1:0] lo_reg, hi_reg;
    logic              spread_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  pick_reg;
    logic [TIME_W-1:0] best_reg;     // best key so far
    logic [TIME_W-1:0] best_time_reg; // free time of the best candidate

    logic [TIME_W-1:0] free_time_reg [MAX_RESOURCES];

    result_t result_reg;
    logic    result_valid_reg;

    // ---------------- shared compare unit ----------------
    logic [CNT_W-1:0]  n_calc;
    logic [CNT_W-1:0]  cnt_inc;
    logic              last;
    logic [2:0]        pk_idx;
    logic [3:0]        cur_level;
    logic [7:0]        cur_cost;
    logic [TIME_W-1:0] rd_time;
    logic [TIME_W-1:0] key;
    logic              capable;
    logic              better;
    logic              spread_cmp;
    logic [TIME_W:0]   fin_sum;
    logic [TIME_W-1:0] fin_time;
    logic              out_free;
    logic              out_load;

    assign n_calc  = (resource_count_reg > 4'(ACT_MAX)) ? CNT_W'(ACT_MAX)
                                                        : CNT_W'(resource_count_reg);
    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign last    = (cnt_inc == n_reg);

    assign pk_idx    = 3'(cnt_reg);
    assign cur_level = resource_levels_reg[{pk_idx, 2'b00} +: 4];
    assign cur_cost  = resource_costs_reg[{pk_idx, 3'b000} +: 8];
    assign rd_time   = free_time_reg[IDX_W'(cnt_reg)];

    // one key: free time under the spread rule, cost otherwise
    assign key     = spread_reg ? rd_time : {16'd0, cur_cost};
    assign capable = (cur_level >= job_reg.job_level);
    assign better  = capable && (!found_reg || (key < best_reg));

    assign spread_cmp = ({1'b0, hi_reg} > ({1'b0, lo_reg} + (TIME_W+1)'(spread_limit_reg)));

    // saturating finish time
    assign fin_sum  = {1'b0, best_time_reg} + (TIME_W+1)'(job_reg.job_length);
    assign fin_time = fin_sum[TIME_W] ? TIME_MAX : fin_sum[TIME_W-1:0];

    assign out_free = !result_valid_reg || result_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                    state_next = (n_calc == '0) ? ST_FINISH : ST_SPREAD;
            end
            ST_SPREAD:
            begin
                if (last)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
                state_next = ST_SELECT;
            ST_SELECT:
            begin
                if (last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        job_ready = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   job_ready = 1'b1;
            ST_FINISH: out_load  = out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_reg    <= job;
                    n_reg      <= n_calc;
                    cnt_reg    <= '0;
                    found_reg  <= 1'b0;
                    spread_reg <= 1'b0;
                    pick_reg   <= '0;
                end
            end
            ST_SPREAD:
            begin
                if (cnt_reg == '0)
                begin
                    lo_reg <= rd_time;
                    hi_reg <= rd_time;
                end
                else
                begin
                    if (rd_time < lo_reg)
                        lo_reg <= rd_time;
                    if (rd_time > hi_reg)
                        hi_reg <= rd_time;
                end
                cnt_reg <= last ? '0 : cnt_inc;
            end
            ST_CHECK:
                spread_reg <= spread_cmp;
            ST_SELECT:
            begin
                if (better)
                begin
                    found_reg     <= 1'b1;
                    best_reg      <= key;
                    best_time_reg <= rd_time;
                    pick_reg      <= IDX_W'(cnt_reg);
                end
                cnt_reg <= cnt_inc;
            end
            default: ;
        endcase

        if (out_load)
        begin
            result_reg.assigned       <= found_reg;
            result_reg.resource_index <= found_reg ? 3'(pick_reg) : 3'd0;
            result_reg.start_time     <= found_reg ? best_time_reg : '0;
            result_reg.finish_time    <= found_reg ? fin_time : '0;
            result_reg.spread_mode    <= spread_reg;
            result_reg.tag_out        <= job_reg.aircraft_tag;
        end
    end

    // free-time table: written once per assigned job, as the result is posted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_RESOURCES; i++)
                free_time_reg[i] <= '0;
        end
        else if (out_load && found_reg)
        begin
            free_time_reg[pick_reg] <= fin_time;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (out_load)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // an unassigned result carries no pick and no times
    a_unassigned_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.assigned) |->
            (result.resource_index == 3'd0 && result.start_time == '0
             && result.finish_time == '0))
        else $error("unassigned result with nonzero pick or times");

    // the finish time never runs behind the start time
    a_finish_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.assigned) |-> (result.finish_time >= result.start_time))
        else $error("finish time below start time");

    // the walk stays inside the resources in use
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPREAD || state_reg == ST_SELECT) |-> (cnt_reg < n_reg))
        else $error("entry counter beyond active resources");

    // a posted result that waits is not overwritten by the next job
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |-> !out_load)
        else $error("result register loaded while occupied");
`endif

endmodule

`default_nettype wire

### tb/capable_resource_dispatcher_core_tb.sv
`default_nettype none

// Self-checking bench for the resource dispatcher.
// - directed table first, then randomized phases with varying idle/stall mixes
// - every accepted job is run through a local dispatch predictor; results are
//   checked in order against the queue of results due
// - one phase keeps a single resource busy with back-to-back long jobs
module capable_resource_dispatcher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crd_pkg::*;

    // resources the packed registers and the core can both hold
    localparam int POOL = (MAX_RESOURCES_DEF < PACKED_ENTRIES) ? MAX_RESOURCES_DEF
                                                               : PACKED_ENTRIES;
    localparam int HOLD_PHASE    = 0;     // phase with the long result back-pressure
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_JOBS    = 200;
    localparam int FILL_JOBS     = 200;   // long jobs on a single resource
    localparam int SETTLE_CYCLES = 2 * POOL + 8;
    localparam int PLAN_ROWS     = 23;

    // ------------------------------------------------------------------
    // DUT hookup; every input is known from time zero
    // ------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                job_valid = 1'b0;
    logic                job_ready;
    job_t                job = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    result_t             result;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    capable_resource_dispatcher_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hard stop in case the handshakes hang
    initial
    begin
        #20_000_000;
        $display("** capable_resource_dispatcher_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and the free times
    // ------------------------------------------------------------------
    logic [3:0]  cfg_count  = COUNT_RST;
    logic [31:0] cfg_levels = LEVELS_RST;
    logic [63:0] cfg_costs  = COSTS_RST;
    logic [15:0] cfg_spread = SPREAD_RST;
    logic [TIME_W-1:0] free_at [POOL];

    typedef struct {
        job_t    j;
        bit      typed;   // want holds a hand-written expectation
        result_t want;
    } queued_job_t;

    queued_job_t jobs_to_send [$];
    queued_job_t on_offer;
    result_t     due_results [$];
    result_t     predicted;

    // knobs driven by the main sequence, read by the drivers
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int phase_id       = -1;

    // bookkeeping; each counter has a single writer process
    int offered_count  = 0;
    int accepted_count = 0;
    int placed_count   = 0;
    int spread_count   = 0;
    int results_seen   = 0;
    int result_errors  = 0;
    int reg_errors     = 0;
    int reg_writes     = 0;
    int hold_left      = 0;
    bit long_hold_done = 1'b0;

    // ------------------------------------------------------------------
    // Dispatch predictor: spread test over the active entries, then the
    // earliest-free or cheapest capable pick, lowest index on ties.
    // Updates free_at for the chosen resource.
    // ------------------------------------------------------------------
    function automatic result_t dispatch_job(job_t j);
        result_t           r;
        int unsigned       n;
        logic [TIME_W-1:0] lo, hi, start, fin;
        logic [TIME_W:0]   sum;
        logic [31:0]       key, best;
        bit                spread, found;
        int unsigned       pick;
        n = cfg_count;
        if (n > POOL)
            n = POOL;
        spread = 1'b0;
        found  = 1'b0;
        pick   = 0;
        best   = '0;
        if (n > 0)
        begin
            lo = free_at[0];
            hi = free_at[0];
            for (int i = 1; i < n; i++)
            begin
                if (free_at[i] > hi) hi = free_at[i];
                if (free_at[i] < lo) lo = free_at[i];
            end
            // 32-bit compare: lo + limit must not wrap
            spread = 32'(hi) > (32'(lo) + 32'(cfg_spread));
        end
        for (int i = 0; i < n; i++)
        begin
            if (cfg_levels[4*i +: 4] >= j.job_level)
            begin
                key = spread ? 32'(free_at[i]) : 32'(cfg_costs[8*i +: 8]);
                if (!found || key < best)
                begin
                    best  = key;
                    pick  = i;
                    found = 1'b1;
                end
            end
        end
        r = '0;
        r.spread_mode = spread;
        r.tag_out     = j.aircraft_tag;
        if (found)
        begin
            start = free_at[pick];
            sum   = {1'b0, start} + (TIME_W+1)'(j.job_length);
            fin   = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
            free_at[pick]    = fin;
            r.assigned       = 1'b1;
            r.resource_index = 3'(pick);
            r.start_time     = start;
            r.finish_time    = fin;
        end
        return r;
    endfunction

    function automatic void report(string msg);
        if (result_errors + reg_errors < 10)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Job sender: offers at the falling edge, holds the payload until the
    // transfer. A just-taken job is replaced in the same step, so valid
    // sees only one update per edge.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!(job_valid && accepted_count != offered_count))
        begin
            if (rst_n && jobs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                on_offer = jobs_to_send.pop_front();
                offered_count++;
                job       <= on_offer.j;
                job_valid <= 1'b1;
            end
            else
            begin
                job_valid <= 1'b0;
            end
        end
    end

    // job transfer: predict and queue what must come back
    always @(posedge clk)
    begin
        if (rst_n && job_valid && job_ready)
        begin
            predicted = dispatch_job(on_offer.j);
            due_results.push_back(on_offer.typed ? on_offer.want : predicted);
            accepted_count++;
            placed_count += predicted.assigned;
            spread_count += predicted.spread_mode;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus one long hold-off at the start
    // of HOLD_PHASE so the output register fills and the job side backs up.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && phase_id == HOLD_PHASE && !long_hold_done)
        begin
            hold_left      = HOLD_CYCLES;
            long_hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want)
        begin
            report($sformatf("result %0d: %s got 0x%0h, expected 0x%0h",
                             results_seen, field, got, want));
            result_errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (due_results.size() == 0)
            begin
                report($sformatf("result with nothing outstanding: 0x%0h", result));
                result_errors++;
            end
            else
            begin
                check_field("assigned",       32'(result.assigned),
                            32'(due_results[0].assigned));
                check_field("resource_index", 32'(result.resource_index),
                            32'(due_results[0].resource_index));
                check_field("start_time",     32'(result.start_time),
                            32'(due_results[0].start_time));
                check_field("finish_time",    32'(result.finish_time),
                            32'(due_results[0].finish_time));
                check_field("spread_mode",    32'(result.spread_mode),
                            32'(due_results[0].spread_mode));
                check_field("tag_out",        32'(result.tag_out),
                            32'(due_results[0].tag_out));
                void'(due_results.pop_front());
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Register access: APB write, then read back the masked value.
    // Only called with the core idle.
    // ------------------------------------------------------------------
    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        logic [63:0] kept;
        logic [63:0] got;
        case (idx)
            REG_COUNT:  kept = value & 64'hF;
            REG_LEVELS: kept = value & 64'hFFFF_FFFF;
            REG_COSTS:  kept = value;
            REG_SPREAD: kept = value & 64'hFFFF;
            default:    kept = '0;
        endcase
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        // write landed on the edge just passed; mirror it
        case (idx)
            REG_COUNT:  cfg_count  = kept[3:0];
            REG_LEVELS: cfg_levels = kept[31:0];
            REG_COSTS:  cfg_costs  = kept;
            REG_SPREAD: cfg_spread = kept[15:0];
            default:    ;
        endcase
        reg_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== kept)
        begin
            report($sformatf("register %s read 0x%0h, expected 0x%0h", idx.name(), got, kept));
            reg_errors++;
        end
    endtask

    // sender stops, everything outstanding comes back
    task automatic wait_drained();
        while (jobs_to_send.size() != 0 || job_valid || due_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic job_t random_job();
        job_t j;
        // half the jobs ask for a low level so most find a resource
        j.job_level    = ($urandom_range(1) != 0) ? 4'($urandom_range(7))
                                                  : 4'($urandom_range(15));
        j.job_length   = 10'($urandom_range(1023));
        j.aircraft_tag = 16'($urandom);
        return j;
    endfunction

    // per-phase register mix; walks count, levels, cost ties and spread extremes
    task automatic setup_phase(int p);
        logic [63:0] costs;
        case (p % 4)
            0:       write_reg(REG_COUNT, 64'd8);
            1:       write_reg(REG_COUNT, 64'd1);
            2:       write_reg(REG_COUNT, 64'($urandom_range(9, 15)));
            default: write_reg(REG_COUNT, 64'($urandom_range(2, 7)));
        endcase
        if (p == 1)
            write_reg(REG_LEVELS, 64'hFFFF_FFFF);
        else
            write_reg(REG_LEVELS, 64'($urandom));
        costs = {32'($urandom), 32'($urandom)};
        if (p == 3)
            costs = '1;
        else if (p % 2 == 0)
            costs &= 64'h0303_0303_0303_0303;  // few cost values -> ties
        write_reg(REG_COSTS, costs);
        case (p % 4)
            0:       write_reg(REG_SPREAD, 64'd0);
            1:       write_reg(REG_SPREAD, 64'hFFFF);
            2:       write_reg(REG_SPREAD, 64'($urandom_range(300)));
            default: write_reg(REG_SPREAD, 64'($urandom_range(65535)));
        endcase
        case (p % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
            default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Directed table. Hand-written results only where obvious: the state
    // right after reset, no capable resource, no resource in use.
    // Fields: kind, register, value, job {level, length, tag}, typed, result
    // {assigned, index, start, finish, spread_mode, tag}.
    // ------------------------------------------------------------------
    typedef enum bit {ROW_JOB, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        reg_idx_t    addr_idx;
        logic [63:0] val;
        job_t        j;
        bit          typed;
        result_t     want;
    } plan_row_t;

    plan_row_t plan [PLAN_ROWS] = '{
        // reset state: all levels 0, all costs 0, all free at 0
        '{ROW_JOB, REG_COUNT, 64'd0, {4'h0, 10'h000, 16'h0000}, 1'b1,
          {1'b1, 3'd0, 24'd0, 24'd0, 1'b0, 16'h0000}},
        '{ROW_JOB, REG_COUNT, 64'd0, {4'h1, 10'h3FF, 16'hFFFF}, 1'b1,
          {1'b0, 3'd0, 24'd0, 24'd0, 1'b0, 16'hFFFF}},
        '{ROW_JOB, REG_COUNT, 64'd0, {4'h0, 10'h3FF, 16'h1234}, 1'b1,
          {1'b1, 3'd0, 24'd0, 24'd1023, 1'b0, 16'h1234}},
        // resource 0 now far ahead: earliest-free rule, tie among the rest
        '{ROW_JOB, REG_COUNT, 64'd0, {4'h0, 10'h007, 16'h0001}, 1'b0, '0},
        '{ROW_CFG, REG_LEVELS, 64'hF0F0_8421, '0, 1'b0, '0},
        '{ROW_CFG, REG_COSTS, 64'h1000_FF20_3040_5060, '0, 1'b0, '0},
        '{ROW_CFG, REG_SPREAD, 64'hFFFF, '0, 1'b0, '0},
        // widest spread limit: cheapest rule only
        '{ROW_JOB, REG_COUNT, 64'd0, {4'hF, 10'h064, 16'hAAAA}, 1'b0, '0},
        '{ROW_JOB, REG_COUNT, 64'd0, {4'h0, 10'h3FF, 16'h5555}, 1'b0, '0},
        '{ROW_JOB, REG_COUNT, 64'd0, {4'h9, 10'h001, 16'h8001}, 1'b0, '0},
        '{ROW_CFG, REG_SPREAD, 64'd0, '0, 1'b0, '0},
        // zero limit: any gap switches to earliest-free
        '{ROW_JOB, REG_COUNT, 64'd0, {4'h4, 10'h3FF, 16'h0F0F}, 1'b0, '0},
        '{ROW_JOB, REG_COUNT, 64'd0, {4'hF, 10'h001, 16'hF0F0}, 1'b0, '0},
        '{ROW_JOB, REG_COUNT, 64'd0, {4'h0, 10'h200, 16'h0002}, 1'b0, '0},
        '{ROW_CFG, REG_COUNT, 64'd0, '0, 1'b0, '0},
        // no resource in use
        '{ROW_JOB, REG_COUNT, 64'd0, {4'h0, 10'h3FF, 16'hBEEF}, 1'b1,
          {1'b0, 3'd0, 24'd0, 24'd0, 1'b0, 16'hBEEF}},
        '{ROW_JOB, REG_COUNT, 64'd0, {4'hF, 10'h000, 16'h0003}, 1'b1,
          {1'b0, 3'd0, 24'd0, 24'd0, 1'b0, 16'h0003}},
        // count above the pool size is clipped
        '{ROW_CFG, REG_COUNT, 64'hF, '0, 1'b0, '0},
        '{ROW_JOB, REG_COUNT, 64'd0, {4'h8, 10'h002, 16'h0004}, 1'b0, '0},
        '{ROW_CFG, REG_COUNT, 64'd1, '0, 1'b0, '0},
        // single resource at level 1: level 2 finds nobody, no spread with one entry
        '{ROW_JOB, REG_COUNT, 64'd0, {4'h2, 10'h001, 16'h0005}, 1'b1,
          {1'b0, 3'd0, 24'd0, 24'd0, 1'b0, 16'h0005}},
        '{ROW_JOB, REG_COUNT, 64'd0, {4'h1, 10'h3FF, 16'h0006}, 1'b0, '0},
        '{ROW_JOB, REG_COUNT, 64'd0, {4'h0, 10'h155, 16'h7FFF}, 1'b0, '0}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        queued_job_t item;
        for (int i = 0; i < POOL; i++)
            free_at[i] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, no idling
        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(plan[r].addr_idx, plan[r].val);
            end
            else
            begin
                item.j     = plan[r].j;
                item.typed = plan[r].typed;
                item.want  = plan[r].want;
                jobs_to_send.push_back(item);
            end
        end

        // random phases; each starts idle with a fresh register set
        item.typed = 1'b0;
        item.want  = '0;
        for (int p = 0; p < 8; p++)
        begin
            wait_drained();
            setup_phase(p);
            phase_id = p;
            for (int k = 0; k < PHASE_JOBS; k++)
            begin
                // sender pause mid-way through the back-pressure phase
                if (p == HOLD_PHASE && k == PHASE_JOBS / 2)
                    wait_drained();
                item.j = random_job();
                jobs_to_send.push_back(item);
            end
        end

        // one resource, long jobs back to back
        wait_drained();
        write_reg(REG_COUNT, 64'd1);
        write_reg(REG_LEVELS, 64'h0000_000F);
        write_reg(REG_SPREAD, 64'd40);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        phase_id       = 8;
        for (int k = 0; k < FILL_JOBS; k++)
        begin
            item.j.job_level    = 4'($urandom_range(15));
            item.j.job_length   = 10'h3FF;
            item.j.aircraft_tag = 16'($urandom);
            jobs_to_send.push_back(item);
        end

        // more resources next to the busy one: wide free-time spread
        wait_drained();
        setup_phase(11);
        phase_id = 9;
        for (int k = 0; k < 200; k++)
        begin
            item.j = random_job();
            jobs_to_send.push_back(item);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d jobs (%0d placed, %0d by earliest-free rule),",
                 accepted_count, placed_count, spread_count);
        $display("%0d register writes, long-job runs and idle/stall mixes; %0d result and %0d %s",
                 reg_writes, result_errors, reg_errors, "register mismatches.");
        if (result_errors == 0 && reg_errors == 0 && due_results.size() == 0)
            $display("** capable_resource_dispatcher_core: PASSED **");
        else
            $display("** capable_resource_dispatcher_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

### capable_resource_dispatcher_core.f
rtl/core/crd_pkg.sv
rtl/core/capable_resource_dispatcher_core.sv
tb/capable_resource_dispatcher_core_tb.sv
